FILE: rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, codes, microcode word layout and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  // Table geometry and field widths.
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int PC_W       = 5;
  localparam int BP_W       = 24;
  localparam int RV_W       = 24;
  localparam int SMP_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int DIV_BITS   = 16;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 42;

  localparam logic [PC_W-1:0]  PC_MIN   = PC_W'(2);
  localparam logic [PC_W-1:0]  PC_MAX   = PC_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

  // Input item kinds carried on tuser.
  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_BELOW = 2'd1,
    CLAMP_ABOVE = 2'd2
  } clamp_t;

  // Table read address sources.
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_LAST,
    RA_IDX,
    RA_IDXP1,
    RA_SEG,
    RA_SEGP1
  } raddr_sel_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_CLAMP_LO,
    OP_CLAMP_HI,
    OP_SCAN,
    OP_LOAD_LO,
    OP_LOAD_HI,
    OP_DIV,
    OP_MUL,
    OP_FINAL,
    OP_EMIT
  } dp_op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_START,
    C_LT,
    C_GE,
    C_SCAN_EMPTY,
    C_SCAN_LAST,
    C_DIV_DONE,
    C_OUT_FREE
  } jump_cond_t;

  typedef logic [3:0] upc_t;

  // Program step addresses.
  localparam upc_t STEP_IDLE     = 4'd0;
  localparam upc_t STEP_RD0      = 4'd1;
  localparam upc_t STEP_CHK_LO   = 4'd2;
  localparam upc_t STEP_CHK_HI   = 4'd3;
  localparam upc_t STEP_SCAN_RD  = 4'd4;
  localparam upc_t STEP_SCAN     = 4'd5;
  localparam upc_t STEP_SEG_RD   = 4'd6;
  localparam upc_t STEP_LOAD_LO  = 4'd7;
  localparam upc_t STEP_LOAD_HI  = 4'd8;
  localparam upc_t STEP_DIV      = 4'd9;
  localparam upc_t STEP_MUL      = 4'd10;
  localparam upc_t STEP_FINAL    = 4'd11;
  localparam upc_t STEP_EMIT     = 4'd12;

  // One control word per program step.
  typedef struct packed {
    raddr_sel_t raddr;
    dp_op_t     op;
    jump_cond_t cond;
    logic       stay;
    upc_t       target;
  } ctrl_word_t;

  // Datapath flags tested by the sequencer.
  typedef struct packed {
    logic start;
    logic lt;
    logic scan_empty;
    logic scan_last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/piecewise_linear_interpolator_top.sv
// A write beat is taken at the idle step and gives no result. An evaluate beat goes
// to the emit step from the lower check when clamped below, from the upper check
// when clamped above, and else through the scan of the inner breakpoints (n active,
// at most 16), the segment loads, a 16-bit divide loop, the multiply and the add.
// Throughput: one item at a time; the next beat is taken once the result is in the
// output register. Reset (rst_n low, synchronous) idles the program, point_count = 2.
// ----------------------------------------------------------------------------
// Piecewise linear interpolator top level
// Microcoded breakpoint search and linear interpolation over a loaded table.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_top
  import pli_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  // Configuration write channel: point_count.
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [4:0]  cfg_data,
  // Input stream.
  input  wire        in_tvalid,
  output logic       in_tready,
  // [3:0] entry_index, [27:4] breakpoint_value, [51:28] rule_value,
  // [83:52] sample, [87:84] zero
  input  wire [87:0] in_tdata,
  // [0] opcode
  input  wire [0:0]  in_tuser,
  // Result stream.
  output logic       out_tvalid,
  input  wire        out_tready,
  // [31:0] value, [35:32] segment, [37:36] clamp_state, [39:38] zero
  output logic [39:0] out_tdata
);

  logic [PC_W-1:0] point_count_r;
  upc_t            upc;
  ctrl_word_t      ctrl;
  dp_status_t      status;
  logic            in_accept;
  logic [SMP_W-1:0] res_value;
  logic [IDX_W-1:0] res_segment;
  clamp_t           res_clamp;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PC_MIN;
    end else if (cfg_valid && cfg_ready) begin
      point_count_r <= cfg_data;
    end
  end

  // Input beats are taken while the program sits at its idle step.
  assign in_tready = (upc == STEP_IDLE);
  assign in_accept = in_tvalid && in_tready;

  pli_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .upc    (upc),
    .ctrl   (ctrl)
  );

  pli_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .status              (status),
    .in_accept           (in_accept),
    .in_opcode           (in_tuser[0]),
    .in_entry_index      (in_tdata[3:0]),
    .in_breakpoint_value (in_tdata[27:4]),
    .in_rule_value       (in_tdata[51:28]),
    .in_sample           (in_tdata[83:52]),
    .point_count         (point_count_r),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_value           (res_value),
    .out_segment         (res_segment),
    .out_clamp_state     (res_clamp)
  );

  // Result beat packing.
  assign out_tdata = {2'b00, res_clamp, res_segment, res_value};

`ifndef NO_ASSERTIONS
  // An evaluate beat keeps the input closed on the following cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[0] == OPC_EVAL) |=> !in_tready)
    else $error("input accepted again right after an evaluate beat");

  // A result only appears out of the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(upc == STEP_EMIT))
    else $error("result raised outside the emit step");

  // The program never leaves its defined steps.
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc <= STEP_EMIT)
    else $error("step counter outside the program");

  // A write beat never disturbs the idle step.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[0] == OPC_WRITE) |=> (upc == STEP_IDLE))
    else $error("write beat started the program");
`endif

endmodule

`default_nettype wire

FILE: rtl/pli_ucode_rom.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator control store
// Read-only program: one control word per step of an evaluate item.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ucode_rom
  import pli_pkg::*;
(
  input  wire upc_t   upc,
  output ctrl_word_t word
);

  // Each step: read address source, datapath op, jump condition,
  // hold when the condition is false, jump target.
  always_comb begin
    case (upc)
      STEP_IDLE:    word = '{RA_ZERO,  OP_IDLE,     C_START,      1'b1, STEP_RD0};
      STEP_RD0:     word = '{RA_ZERO,  OP_NOP,      C_NEVER,      1'b0, STEP_IDLE};
      STEP_CHK_LO:  word = '{RA_LAST,  OP_CLAMP_LO, C_LT,         1'b0, STEP_EMIT};
      STEP_CHK_HI:  word = '{RA_ZERO,  OP_CLAMP_HI, C_GE,         1'b0, STEP_EMIT};
      STEP_SCAN_RD: word = '{RA_IDX,   OP_NOP,      C_SCAN_EMPTY, 1'b0, STEP_SEG_RD};
      STEP_SCAN:    word = '{RA_IDXP1, OP_SCAN,     C_SCAN_LAST,  1'b1, STEP_SEG_RD};
      STEP_SEG_RD:  word = '{RA_SEG,   OP_NOP,      C_NEVER,      1'b0, STEP_IDLE};
      STEP_LOAD_LO: word = '{RA_SEGP1, OP_LOAD_LO,  C_NEVER,      1'b0, STEP_IDLE};
      STEP_LOAD_HI: word = '{RA_ZERO,  OP_LOAD_HI,  C_NEVER,      1'b0, STEP_IDLE};
      STEP_DIV:     word = '{RA_ZERO,  OP_DIV,      C_DIV_DONE,   1'b1, STEP_MUL};
      STEP_MUL:     word = '{RA_ZERO,  OP_MUL,      C_NEVER,      1'b0, STEP_IDLE};
      STEP_FINAL:   word = '{RA_ZERO,  OP_FINAL,    C_NEVER,      1'b0, STEP_IDLE};
      STEP_EMIT:    word = '{RA_ZERO,  OP_EMIT,     C_OUT_FREE,   1'b1, STEP_IDLE};
      default:      word = '{RA_ZERO,  OP_NOP,      C_ALWAYS,     1'b0, STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pli_seq.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator sequencer
// Step counter with conditional jumps over the control store.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_seq
  import pli_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire dp_status_t status,
  output upc_t        upc,
  output ctrl_word_t  ctrl
);

  upc_t upc_r;
  upc_t upc_nxt;
  logic take;

  pli_ucode_rom u_rom (
    .upc  (upc_r),
    .word (ctrl)
  );

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (ctrl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_START:      take = status.start;
      C_LT:         take = status.lt;
      C_GE:         take = !status.lt;
      C_SCAN_EMPTY: take = status.scan_empty;
      C_SCAN_LAST:  take = status.scan_last;
      C_DIV_DONE:   take = status.div_done;
      C_OUT_FREE:   take = status.out_free;
      default:      take = 1'b0;
    endcase
  end

  // Jump, hold or fall through to the next step.
  always_comb begin
    if (take) begin
      upc_nxt = ctrl.target;
    end else if (ctrl.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign upc = upc_r;

endmodule

`default_nettype wire

FILE: rtl/pli_datapath.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator datapath
// Table memories, compare, restoring divider, multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_datapath
  import pli_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire ctrl_word_t        ctrl,
  output dp_status_t             status,
  input  wire                    in_accept,
  input  wire                    in_opcode,
  input  wire [IDX_W-1:0]        in_entry_index,
  input  wire [BP_W-1:0]         in_breakpoint_value,
  input  wire [RV_W-1:0]         in_rule_value,
  input  wire [SMP_W-1:0]        in_sample,
  input  wire [PC_W-1:0]         point_count,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [SMP_W-1:0]       out_value,
  output logic [IDX_W-1:0]       out_segment,
  output clamp_t                 out_clamp_state
);

  // Breakpoint and rule tables.
  logic [BP_W-1:0] bp_mem [MAX_POINTS];
  logic [RV_W-1:0] rv_mem [MAX_POINTS];
  logic [BP_W-1:0] bp_rd_r;
  logic [RV_W-1:0] rv_rd_r;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;

  // Working registers.
  logic signed [SMP_W-1:0] s_r, s_nxt;
  logic [PC_W-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        seg_r, seg_nxt;
  clamp_t                  clamp_r, clamp_nxt;
  logic [SMP_W-1:0]        res_r, res_nxt;
  logic [SMP_W-1:0]        lo_r, lo_nxt;
  logic [RV_W-1:0]         rv_lo_r, rv_lo_nxt;
  logic [SMP_W-1:0]        span_r, span_nxt;
  logic [SMP_W-1:0]        rem_r, rem_nxt;
  logic [RV_W:0]           diff_r, diff_nxt;
  logic [DIV_BITS-1:0]     w_r, w_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]        out_value_r, out_value_nxt;
  logic [IDX_W-1:0]        out_seg_r, out_seg_nxt;
  clamp_t                  out_clamp_r, out_clamp_nxt;

  // Combinational helpers.
  logic [SMP_W-1:0]  bp_q;
  logic [SMP_W-1:0]  rv_q;
  logic              lt;
  logic [PC_W-1:0]   n_in;
  logic [PC_W-1:0]   n_m1;
  logic [SMP_W:0]    rem2;
  logic [SMP_W:0]    div_sub;
  logic              div_ge;
  logic [PROD_W-1:0] rnd;
  logic              out_free;

  assign bp_q     = {bp_rd_r, {FRAC_W{1'b0}}};
  assign rv_q     = {rv_rd_r, {FRAC_W{1'b0}}};
  assign lt       = $signed(s_r) < $signed(bp_q);
  assign n_m1     = n_r - PC_W'(1);
  assign out_free = !out_valid_r || out_ready;
  assign wr_en    = in_accept && (in_opcode == OPC_WRITE);

  // Point count saturated to the legal range at item entry.
  always_comb begin
    if (point_count < PC_MIN) begin
      n_in = PC_MIN;
    end else if (point_count > PC_MAX) begin
      n_in = PC_MAX;
    end else begin
      n_in = point_count;
    end
  end

  // Table read address.
  always_comb begin
    case (ctrl.raddr)
      RA_ZERO:  raddr = '0;
      RA_LAST:  raddr = n_m1[IDX_W-1:0];
      RA_IDX:   raddr = i_r;
      RA_IDXP1: raddr = i_r + IDX_W'(1);
      RA_SEG:   raddr = seg_r;
      RA_SEGP1: raddr = seg_r + IDX_W'(1);
      default:  raddr = '0;
    endcase
  end

  // Table write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bp_mem[in_entry_index] <= in_breakpoint_value;
      rv_mem[in_entry_index] <= in_rule_value;
    end
    bp_rd_r <= bp_mem[raddr];
    rv_rd_r <= rv_mem[raddr];
  end

  // One restoring division step.
  assign rem2    = {rem_r, 1'b0};
  assign div_ge  = rem2 >= {1'b0, span_r};
  assign div_sub = rem2 - {1'b0, span_r};

  // Round the weighted difference to the nearest Q24.8 step.
  assign rnd = prod_r + PROD_W'(128);

  // Status for the sequencer.
  always_comb begin
    status.start      = in_accept && (in_opcode == OPC_EVAL);
    status.lt         = lt;
    status.scan_empty = {1'b0, i_r} >= n_m1;
    status.scan_last  = ({1'b0, i_r} + PC_W'(1)) >= n_m1;
    status.div_done   = cnt_r == DIV_LAST;
    status.out_free   = out_free;
  end

  // Datapath operations.
  always_comb begin
    s_nxt         = s_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    seg_nxt       = seg_r;
    clamp_nxt     = clamp_r;
    res_nxt       = res_r;
    lo_nxt        = lo_r;
    rv_lo_nxt     = rv_lo_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    diff_nxt      = diff_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_value_nxt = out_value_r;
    out_seg_nxt   = out_seg_r;
    out_clamp_nxt = out_clamp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (ctrl.op)
      OP_IDLE: begin
        if (status.start) begin
          s_nxt = $signed(in_sample);
          n_nxt = n_in;
        end
      end
      OP_CLAMP_LO: begin
        res_nxt   = rv_q;
        seg_nxt   = '0;
        clamp_nxt = CLAMP_BELOW;
      end
      OP_CLAMP_HI: begin
        i_nxt = IDX_W'(1);
        if (!lt) begin
          res_nxt   = rv_q;
          seg_nxt   = n_m1[IDX_W-1:0];
          clamp_nxt = CLAMP_ABOVE;
        end else begin
          seg_nxt = '0;
        end
      end
      OP_SCAN: begin
        if (!lt) begin
          seg_nxt = i_r;
        end
        i_nxt = i_r + IDX_W'(1);
      end
      OP_LOAD_LO: begin
        lo_nxt    = bp_q;
        rv_lo_nxt = rv_rd_r;
      end
      OP_LOAD_HI: begin
        span_nxt = bp_q - lo_r;
        rem_nxt  = s_r - lo_r;
        diff_nxt = {rv_rd_r[RV_W-1], rv_rd_r} - {rv_lo_r[RV_W-1], rv_lo_r};
        cnt_nxt  = '0;
        w_nxt    = '0;
      end
      OP_DIV: begin
        rem_nxt = div_ge ? div_sub[SMP_W-1:0] : rem2[SMP_W-1:0];
        w_nxt   = {w_r[DIV_BITS-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_MUL: begin
        // Signed 25-bit difference times the unsigned 16-bit weight.
        prod_nxt = $signed(diff_r) * $signed({1'b0, w_r});
      end
      OP_FINAL: begin
        res_nxt   = {rv_lo_r, {FRAC_W{1'b0}}} + rnd[SMP_W+FRAC_W-1:FRAC_W];
        clamp_nxt = CLAMP_NONE;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_seg_nxt   = seg_r;
          out_clamp_nxt = clamp_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    seg_r       <= seg_nxt;
    clamp_r     <= clamp_nxt;
    res_r       <= res_nxt;
    lo_r        <= lo_nxt;
    rv_lo_r     <= rv_lo_nxt;
    span_r      <= span_nxt;
    rem_r       <= rem_nxt;
    diff_r      <= diff_nxt;
    w_r         <= w_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_seg_r   <= out_seg_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  // Result beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_segment     = out_seg_r;
  assign out_clamp_state = out_clamp_r;

endmodule

`default_nettype wire

FILE: tb/piecewise_linear_interpolator_top_tb.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables over the input stream, evaluates samples against
// them and checks every result beat against a scoreboard that tracks the
// table, the breakpoint count and the expected value, segment and clamp kind.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  // Cycles to let pass after the last result before touching the config port.
  localparam int     SETTLE_CYCLES = 64;
  localparam longint SMP_MIN       = -(longint'(1) <<< 31);
  localparam longint SMP_MAX       = (longint'(1) <<< 31) - 1;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  segment;
    clamp_t      clamp;
  } interp_result_t;

  // Tracks the table contents and predicts each evaluate result.
  class interp_scoreboard;
    int             bp_tab [MAX_POINTS];
    int             rv_tab [MAX_POINTS];
    bit [PC_W-1:0]  point_count;
    interp_result_t pending_q [$];
    int             mismatches;

    function new();
      point_count = PC_MIN;
      mismatches  = 0;
      foreach (bp_tab[k]) begin
        bp_tab[k] = 0;
        rv_tab[k] = 0;
      end
    endfunction

    function int active_points();
      if (point_count < PC_MIN) return PC_MIN;
      if (point_count > PC_MAX) return PC_MAX;
      return point_count;
    endfunction

    function void set_point_count(bit [PC_W-1:0] v);
      point_count = v;
    endfunction

    // Notes one accepted input beat; evaluate beats queue their result.
    function void record_item(logic op, logic [IDX_W-1:0] idx, logic [BP_W-1:0] bp,
                              logic [RV_W-1:0] rv, logic [SMP_W-1:0] smp);
      int             n;
      int             seg;
      longint         s, lo, span, d, w, delta, term, res;
      interp_result_t exp_r;
      if (op == OPC_WRITE) begin
        bp_tab[idx] = $signed(bp);
        rv_tab[idx] = $signed(rv);
        return;
      end
      n = active_points();
      s = longint'($signed(smp));
      if (s < longint'(bp_tab[0]) * 256) begin
        res         = longint'(rv_tab[0]) * 256;
        seg         = 0;
        exp_r.clamp = CLAMP_BELOW;
      end else if (s >= longint'(bp_tab[n-1]) * 256) begin
        res         = longint'(rv_tab[n-1]) * 256;
        seg         = n - 1;
        exp_r.clamp = CLAMP_ABOVE;
      end else begin
        // Last lower breakpoint at or below the sample wins.
        seg = 0;
        for (int i = 1; i + 1 < n; i++) begin
          if (longint'(bp_tab[i]) * 256 <= s) seg = i;
        end
        lo   = longint'(bp_tab[seg]) * 256;
        span = longint'(bp_tab[seg+1]) * 256 - lo;
        d    = s - lo;
        if (span <= 0 || d < 0) begin
          w = 0;
        end else begin
          w = (d <<< 16) / span;
          if (w > 65535) w = 65535;
        end
        delta       = longint'(rv_tab[seg+1] - rv_tab[seg]) * 256;
        term        = (delta * w + 32768) >>> 16;
        res         = longint'(rv_tab[seg]) * 256 + term;
        exp_r.clamp = CLAMP_NONE;
      end
      exp_r.value   = res[31:0];
      exp_r.segment = seg[3:0];
      pending_q.push_back(exp_r);
    endfunction

    // Compares one result beat with the oldest expected result.
    function void check_result(logic [39:0] beat);
      interp_result_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with no evaluate pending: value=%h segment=%0d clamp=%0d",
                   beat[31:0], beat[35:32], beat[37:36]);
        return;
      end
      exp_r = pending_q.pop_front();
      if (beat[31:0] !== exp_r.value || beat[35:32] !== exp_r.segment ||
          beat[37:36] !== exp_r.clamp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%h segment=%0d clamp=%0d, got value=%h segment=%0d clamp=%0d",
                   exp_r.value, exp_r.segment, exp_r.clamp,
                   beat[31:0], beat[35:32], beat[37:36]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  bit               idle_en = 1'b1;
  interp_scoreboard board;

  piecewise_linear_interpolator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("piecewise_linear_interpolator_top_tb: FAIL");
    $finish;
  end

  // Result side: random stall bursts while idling is enabled.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Drives one input beat; called and returns at a falling edge.
  task automatic send_item(input logic op, input logic [3:0] idx, input logic [23:0] bp,
                           input logic [23:0] rv, input logic [31:0] smp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {4'd0, smp, rv, bp, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.record_item(op, idx, bp, rv, smp);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_entry(input logic [3:0] idx, input logic [23:0] bp,
                             input logic [23:0] rv);
    send_item(OPC_WRITE, idx, bp, rv, $urandom);
  endtask

  task automatic evaluate(input logic [31:0] smp);
    send_item(OPC_EVAL, 4'($urandom), 24'($urandom), 24'($urandom), smp);
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic settle();
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_point_count(input logic [4:0] v);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_point_count(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stimulus.
  initial begin : stimulus
    bit [4:0]        pc_plan [10];
    bit [4:0]        pc;
    int              vals [MAX_POINTS];
    int              ph, k, e, i, j, n, kind, base, tmp, r;
    bit [3:0]        off;
    longint          lo_q, hi_q, smp_q;
    longint unsigned rnd64;

    pc_plan   = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd2, 5'd9, 5'd16, 5'd5};
    board     = new();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme two-point table at the reset breakpoint count.
    write_entry(4'd0, 24'(-8388608), 24'(8388607));
    write_entry(4'd1, 24'(8388607), 24'(-8388608));
    for (k = 2; k < MAX_POINTS; k++)
      write_entry(4'(k), 24'(k * 1000), 24'(100 - k * 37));
    evaluate(32'h8000_0000);  // exactly on the first breakpoint
    evaluate(32'h7FFF_FFFF);  // above the last breakpoint
    evaluate(32'h7FFF_FEFF);  // just under the last breakpoint
    evaluate(32'h0000_0000);
    evaluate(32'h0000_0080);
    // Move the first breakpoint up to reach the lower clamp.
    write_entry(4'd0, 24'd0, 24'(-8388608));
    evaluate(32'hFFFF_FFFF);
    evaluate(32'h0000_0000);
    evaluate(32'h8000_0000);

    // Random phases, each with its own breakpoint count and table.
    for (ph = 0; ph < 10; ph++) begin
      if (ph >= 8) idle_en = 1'b0;
      pc = (ph == 7) ? 5'($urandom) : pc_plan[ph];
      settle();
      write_point_count(pc);

      // Mostly ascending tables; some narrow, some with repeats, some unordered.
      kind = (ph == 0) ? 0 : $urandom_range(0, 5);
      base = int'($urandom_range(0, 16777215 - 4000)) - 8388608;
      for (k = 0; k < MAX_POINTS; k++) begin
        case (kind)
          3:       vals[k] = base + int'($urandom_range(0, 4000));
          4:       vals[k] = base + int'($urandom_range(0, 12));
          default: vals[k] = int'($signed(24'($urandom)));
        endcase
      end
      if (kind != 5) begin
        for (i = 0; i < MAX_POINTS - 1; i++)
          for (j = 0; j < MAX_POINTS - 1 - i; j++)
            if (vals[j] > vals[j+1]) begin
              tmp       = vals[j];
              vals[j]   = vals[j+1];
              vals[j+1] = tmp;
            end
      end
      off = 4'($urandom);
      for (k = 0; k < MAX_POINTS; k++) begin
        i = (k + off) % MAX_POINTS;
        write_entry(4'(i), 24'(vals[i]),
                    ($urandom_range(0, 2) == 0) ? 24'(int'($urandom_range(0, 200)) - 100)
                                                : 24'($urandom));
      end

      for (e = 0; e < 30; e++) begin
        // An occasional stray entry write between evaluations.
        if ($urandom_range(0, 14) == 0)
          write_entry(4'($urandom), 24'($urandom), 24'($urandom));
        n = board.active_points();
        r = $urandom_range(0, 9);
        if (r <= 5) begin
          i     = $urandom_range(0, n - 2);
          lo_q  = longint'(board.bp_tab[i]) * 256;
          hi_q  = longint'(board.bp_tab[i+1]) * 256;
          rnd64 = {$urandom, $urandom};
          smp_q = (hi_q > lo_q) ? lo_q + longint'(rnd64 % unsigned'(hi_q - lo_q))
                                : lo_q;
        end else if (r == 6) begin
          smp_q = longint'(board.bp_tab[$urandom_range(0, n - 1)]) * 256
                  + longint'($urandom_range(0, 2)) - 1;
        end else if (r == 7) begin
          smp_q = longint'(board.bp_tab[0]) * 256 - longint'($urandom_range(1, 1000));
        end else if (r == 8) begin
          smp_q = longint'(board.bp_tab[n-1]) * 256 + longint'($urandom_range(0, 1000));
        end else begin
          smp_q = longint'($signed($urandom));
        end
        if (smp_q < SMP_MIN) smp_q = SMP_MIN;
        if (smp_q > SMP_MAX) smp_q = SMP_MAX;
        evaluate(smp_q[31:0]);
      end
    end

    settle();
    if (board.mismatches == 0) begin
      $display("piecewise_linear_interpolator_top_tb: PASS");
    end else begin
      $display("piecewise_linear_interpolator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
